### sv/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants for the difficulty retarget block
// Holds the job record that travels from the front end to the engine,
// the configuration record and the arithmetic widths.
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam int DRT_LIMIT_ZERO_BITS = 20;

    localparam int TGT_BITS  = 256;
    localparam int TS_W      = 33;                  // clamped timespan, never negative
    localparam int PROD_W    = TGT_BITS + TS_W;     // exact target * timespan
    localparam int REM_W     = 33;                  // divider remainder
    localparam int CNT_W     = 9;                   // counts up to PROD_W steps
    localparam int MOD_STEPS = 32;

    // Reciprocals scaled by 2^39 and rounded up. For any 32-bit target
    // timespan t, (t * RECIP) >> 39 equals t * 100 / 103 (or / 115) exactly.
    localparam logic [38:0] RECIP_ABOVE = 39'd533743508630;
    localparam logic [38:0] RECIP_BELOW = 39'd478048533816;

    localparam logic [1:0] REG_TARGET_TIMESPAN   = 2'd0;
    localparam logic [1:0] REG_ADJUST_INTERVAL   = 2'd1;
    localparam logic [1:0] REG_RETARGET_DISABLED = 2'd2;
    localparam logic [1:0] REG_SWITCH_HEIGHT     = 2'd3;

    typedef struct packed {
        logic [31:0] target_timespan;
        logic [15:0] adjust_interval;
        logic        retarget_disabled;
        logic [30:0] switch_height;
    } t_cfg;

    typedef struct packed {
        logic               pass;       // word goes out unchanged
        logic [30:0]        height;
        logic [31:0]        height_p1;
        logic [31:0]        last_compact;
        logic signed [32:0] timespan;   // last_time - first_time
    } t_job;

endpackage

### sv/drt_front.sv
// ----------------------------------------------------------------------------
// drt_front: configuration registers and request classification
// Holds the register file and turns each request into a job record for
// the queue, marking requests that can never trigger a retarget.
// ----------------------------------------------------------------------------
module drt_front
    import drt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic [30:0] i_last_height,
    input  logic [31:0] i_last_compact,
    input  logic [31:0] i_last_time,
    input  logic [31:0] i_first_time,
    output t_cfg        o_cfg,
    output t_job        o_job
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_timespan   <= 32'd3600;
            r_cfg.adjust_interval   <= 16'd20;
            r_cfg.retarget_disabled <= 1'b0;
            r_cfg.switch_height     <= 31'd3500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET_TIMESPAN:   r_cfg.target_timespan   <= i_cfg_data;
                REG_ADJUST_INTERVAL:   r_cfg.adjust_interval   <= i_cfg_data[15:0];
                REG_RETARGET_DISABLED: r_cfg.retarget_disabled <= i_cfg_data[0];
                REG_SWITCH_HEIGHT:     r_cfg.switch_height     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    always_comb begin
        o_job.pass         = (r_cfg.adjust_interval == 16'd0) || r_cfg.retarget_disabled
                             || (r_cfg.target_timespan == 32'd0);
        o_job.height       = i_last_height;
        o_job.height_p1    = {1'b0, i_last_height} + 32'd1;
        o_job.last_compact = i_last_compact;
        o_job.timespan     = $signed({1'b0, i_last_time}) - $signed({1'b0, i_first_time});
    end

endmodule

### sv/drt_queue.sv
// ----------------------------------------------------------------------------
// drt_queue: two-entry job queue
// Decouples request intake from the retarget engine.
// ----------------------------------------------------------------------------
module drt_queue
    import drt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];

endmodule

### sv/drt_engine.sv
// ----------------------------------------------------------------------------
// drt_engine: sequential retarget engine with output register
// Runs boundary check, clamp, 256-bit decode, bit-serial multiply,
// restoring divide, cap and compact encode on one shared datapath.
// ----------------------------------------------------------------------------
module drt_engine
    import drt_pkg::*;
#(
    parameter int LIMIT_ZERO_BITS = DRT_LIMIT_ZERO_BITS
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_next_compact
);

    localparam int LIMIT_POS = TGT_BITS - LIMIT_ZERO_BITS;
    localparam logic [TGT_BITS-1:0] LIMIT = {TGT_BITS{1'b1}} >> LIMIT_ZERO_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_CDIV  = 4'd3;
    localparam logic [3:0] S_CLAMP = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_CAP   = 4'd7;
    localparam logic [3:0] S_NORM  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_RMUL  = 4'd10;

    logic [3:0]          r_state;
    t_job                r_job;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-1:0]   r_mcand;
    logic [TS_W-1:0]     r_mplier;
    logic [REM_W-1:0]    r_rem;
    logic [31:0]         r_dvs;
    logic [CNT_W-1:0]    r_cnt;
    logic [TGT_BITS-1:0] r_w;
    logic [5:0]          r_size;
    logic [31:0]         r_result;
    logic                r_ovalid;
    logic [31:0]         r_out;
    logic [38:0]         r_recip;
    logic [51:0]         r_rec_lo;
    logic [31:0]         r_qc;
    logic                out_load;

    // Shared restoring divider step.
    logic [REM_W-1:0]    rem_sh;
    logic                rem_ge;
    logic [REM_W-1:0]    rem_nx;

    always_comb begin
        rem_sh = {r_rem[REM_W-2:0], r_acc[PROD_W-1]};
        rem_ge = (rem_sh >= {1'b0, r_dvs});
        rem_nx = rem_ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    // Constant division of the clamp floor, done as a reciprocal multiply
    // in two halves: the low half is registered, the high half added after.
    logic [50:0]          rec_hi;
    logic [70:0]          rec_sum;

    always_comb begin
        rec_hi  = 51'(i_cfg.target_timespan) * 51'(r_recip[38:20]);
        rec_sum = {rec_hi, 20'd0} + {19'd0, r_rec_lo};
    end

    // Clamp of the observed timespan and decode of the compact word.
    logic signed [34:0]   ts_x;
    logic signed [34:0]   quarter;
    logic signed [34:0]   qconst;
    logic signed [34:0]   twice;
    logic signed [34:0]   ts_c;
    logic [7:0]           expo;
    logic [22:0]          mant;
    logic [7:0]           shb;
    logic [TGT_BITS-1:0]  decoded;

    always_comb begin
        ts_x    = 35'(r_job.timespan);
        quarter = $signed({5'd0, i_cfg.target_timespan[31:2]});
        qconst  = $signed({3'd0, r_qc});
        twice   = $signed({2'd0, i_cfg.target_timespan, 1'b0});
        ts_c    = ts_x;
        if (r_job.height >= i_cfg.switch_height) begin
            if (ts_x < quarter) begin
                ts_c = qconst;
            end
        end else if (ts_x < qconst) begin
            ts_c = qconst;
        end
        if (ts_c > twice) begin
            ts_c = twice;
        end

        expo    = r_job.last_compact[31:24];
        mant    = r_job.last_compact[22:0];
        shb     = expo - 8'd3;
        decoded = '0;
        if (expo <= 8'd3) begin
            decoded = {{(TGT_BITS-23){1'b0}}, mant >> {(2'd3 - expo[1:0]), 3'b000}};
        end else if (shb < 8'd32) begin
            decoded = {{(TGT_BITS-23){1'b0}}, mant} << {shb[4:0], 3'b000};
        end
    end

    logic [23:0] enc_mant;
    always_comb begin
        enc_mant = r_w[TGT_BITS-1:TGT_BITS-24];
    end

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job    <= i_q_job;
                        r_result <= i_q_job.last_compact;
                        if (i_q_job.pass) begin
                            r_state <= S_DONE;
                        end else begin
                            r_acc   <= {i_q_job.height_p1, {(PROD_W-32){1'b0}}};
                            r_dvs   <= {16'd0, i_cfg.adjust_interval};
                            r_rem   <= '0;
                            r_cnt   <= CNT_W'(MOD_STEPS);
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD, S_DIV: begin
                    r_rem <= rem_nx;
                    r_acc <= {r_acc[PROD_W-2:0], rem_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        unique case (r_state)
                            S_MOD:   r_state <= S_CHK;
                            default: r_state <= S_CAP;
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_rem != '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_recip <= (r_job.height >= i_cfg.switch_height)
                                   ? RECIP_ABOVE : RECIP_BELOW;
                        r_state <= S_CDIV;
                    end
                end
                S_CDIV: begin
                    r_rec_lo <= 52'(i_cfg.target_timespan) * 52'(r_recip[19:0]);
                    r_state  <= S_RMUL;
                end
                S_RMUL: begin
                    r_qc    <= rec_sum[70:39];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_mplier <= ts_c[TS_W-1:0];
                    r_mcand  <= {{TS_W{1'b0}}, decoded};
                    r_acc    <= '0;
                    r_cnt    <= CNT_W'(TS_W);
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[TS_W-1:1]};
                    if (r_cnt == CNT_W'(1)) begin
                        r_dvs   <= i_cfg.target_timespan;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(PROD_W);
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_CAP: begin
                    r_w     <= (|r_acc[PROD_W-1:LIMIT_POS]) ? LIMIT : r_acc[TGT_BITS-1:0];
                    r_size  <= 6'd32;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // Left-justify the value one byte per cycle; the top three
                    // bytes then hold the mantissa for every size.
                    if ((r_size != 6'd0) && (r_w[TGT_BITS-1:TGT_BITS-8] == 8'd0)) begin
                        r_w    <= {r_w[TGT_BITS-9:0], 8'd0};
                        r_size <= r_size - 6'd1;
                    end else begin
                        if (enc_mant[23]) begin
                            r_result <= {2'd0, r_size + 6'd1, 8'd0, enc_mant[23:8]};
                        end else begin
                            r_result <= {2'd0, r_size, enc_mant};
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out   <= r_result;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_next_compact = r_out;

endmodule

### sv/difficulty_retarget.sv
// ----------------------------------------------------------------------------
// difficulty_retarget: next compact difficulty word
// A pass request (retargeting off, zero interval or zero target timespan) goes
// straight to the output register. Off an adjustment boundary the engine runs
// the modulo steps and returns the word unchanged; on a boundary it runs modulo,
// reciprocal clamp, bit-serial multiply and divide, cap and encode. Output stalls
// hold the engine; it serves one request at a time, queuing up to two more.
// Reset: synchronous, active low; config registers return to their defaults.
// ----------------------------------------------------------------------------
module difficulty_retarget
    import drt_pkg::*;
#(
    parameter int LIMIT_ZERO_BITS = DRT_LIMIT_ZERO_BITS
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [30:0] i_last_height,
    input  logic [31:0] i_last_compact,
    input  logic [31:0] i_last_time,
    input  logic [31:0] i_first_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_next_compact
);

    t_cfg cfg;
    t_job fr_job;
    t_job q_job;
    logic q_full;
    logic q_valid;
    logic q_pop;

    drt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_last_height  (i_last_height),
        .i_last_compact (i_last_compact),
        .i_last_time    (i_last_time),
        .i_first_time   (i_first_time),
        .o_cfg          (cfg),
        .o_job          (fr_job)
    );

    assign o_ready = !q_full;

    drt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_job   (fr_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    drt_engine #(
        .LIMIT_ZERO_BITS (LIMIT_ZERO_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_valid      (q_valid),
        .i_q_job        (q_job),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_next_compact (o_next_compact)
    );

endmodule
